### sv/wrg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wrg_pkg
// Shared types, codes and arithmetic helpers of the waypoint reference
// generator
// ----------------------------------------------------------------------------
package wrg_pkg;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 31;

    localparam logic [CFG_IDX_W-1:0] CFG_TICK_PERIOD = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ARRIVE_TOL  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LOOKAHEAD   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPEED_LIM   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ACCEL_LIM   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_YAW_RATE    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_STALE_TICKS = 3'd6;

    localparam logic [16:0] RST_TICK_PERIOD = 17'd3277;
    localparam logic [30:0] RST_ARRIVE_TOL  = 31'd19661;
    localparam logic [30:0] RST_LOOKAHEAD   = 31'd65536;
    localparam logic [30:0] RST_SPEED_LIM   = 31'd131072;
    localparam logic [30:0] RST_ACCEL_LIM   = 31'd65536;
    localparam logic [30:0] RST_YAW_RATE    = 31'd65536;
    localparam logic [15:0] RST_STALE_TICKS = 16'd40;

    typedef enum logic [1:0] {
        CMD_TICK     = 2'd0,
        CMD_WAYPOINT = 2'd1,
        CMD_EMPTY    = 2'd2
    } t_cmd;

    // constants; the angles and the yaw speed threshold are Q16.16
    localparam logic signed [33:0] Q_PI          = 34'sd205887;
    localparam logic signed [33:0] Q_TWO_PI      = 34'sd411774;
    localparam logic signed [31:0] Q_PI_2        = 32'sd102944;
    localparam logic [31:0]        YAW_SPEED_MIN = 32'd13107;
    localparam logic [3:0]         STARTUP_END   = 4'd11;
    localparam logic [15:0]        TICKS_MAX     = 16'hFFFF;
    localparam logic [4:0]         STEP_LAST     = 5'd31;
    localparam logic [4:0]         CORDIC_LAST   = 5'd16;
    localparam logic [63:0]        SQRT_BIT_TOP  = 64'h4000_0000_0000_0000;

    localparam logic signed [33:0] S32_MAX = 34'sd2147483647;
    localparam logic signed [33:0] S32_MIN = -34'sd2147483648;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
    } t_point;

    typedef enum logic [5:0] {
        S_IDLE, S_PUSH,
        S_DROP_CHK, S_DROP_RD, S_DROP_CMP,
        S_CAR, S_CAR_MUL, S_CAR_CMP, S_SPD_SET,
        S_VD_MUL, S_VD_DIV, S_VD_SET,
        S_LIM, S_LIM_DV, S_LIM_CMP,
        S_SC_MUL, S_SC_DIV, S_SC_SET,
        S_VEL, S_POS_MUL, S_POS_ADD,
        S_YAW, S_YAW_CMP, S_CORDIC, S_WRAP, S_MDY_MUL, S_CLAMP, S_YAW_SET,
        S_EMIT,
        S_SQ_MUL, S_SQ_ACC, S_SQRT, S_DIV
    } t_state;

    function automatic logic signed [33:0] ext34(input logic signed [31:0] v);
        return {{2{v[31]}}, v};
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
        logic signed [31:0] r;
        if (v > S32_MAX) begin
            r = 32'sh7FFF_FFFF;
        end else if (v < S32_MIN) begin
            r = 32'sh8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    // product scaled down by 2^16, truncated toward zero
    function automatic logic signed [33:0] tz16(input logic signed [65:0] p);
        logic signed [65:0] t;
        t = p[65] ? p + 66'sd65535 : p;
        return t[49:16];
    endfunction

    function automatic logic [16:0] atan_entry(input logic [4:0] i);
        logic [16:0] r;
        case (i)
            5'd0:    r = 17'd51472;
            5'd1:    r = 17'd30385;
            5'd2:    r = 17'd16055;
            5'd3:    r = 17'd8150;
            5'd4:    r = 17'd4091;
            5'd5:    r = 17'd2047;
            5'd6:    r = 17'd1024;
            5'd7:    r = 17'd512;
            5'd8:    r = 17'd256;
            5'd9:    r = 17'd128;
            5'd10:   r = 17'd64;
            5'd11:   r = 17'd32;
            5'd12:   r = 17'd16;
            5'd13:   r = 17'd8;
            5'd14:   r = 17'd4;
            5'd15:   r = 17'd2;
            5'd16:   r = 17'd1;
            default: r = 17'd0;
        endcase
        return r;
    endfunction

endpackage

### sv/wrg_channels.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wrg channels
// Valid/ready channel interfaces for items, results and configuration writes
// ----------------------------------------------------------------------------
interface wrg_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         command;
    logic               first_of_path;
    logic signed [31:0] waypoint_x;
    logic signed [31:0] waypoint_y;
    logic signed [31:0] waypoint_z;

    modport source (output valid, command, first_of_path, waypoint_x, waypoint_y,
                    waypoint_z, input ready);
    modport sink   (input valid, command, first_of_path, waypoint_x, waypoint_y,
                    waypoint_z, output ready);
endinterface

interface wrg_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] north;
    logic signed [31:0] east;
    logic signed [31:0] down;
    logic signed [19:0] heading_ned;
    logic               engage_now;
    logic               plan_active;

    modport source (output valid, north, east, down, heading_ned, engage_now,
                    plan_active, input ready);
    modport sink   (input valid, north, east, down, heading_ned, engage_now,
                    plan_active, output ready);
endinterface

interface wrg_cfg_if;
    import wrg_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

### sv/waypoint_reference_generator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// waypoint_reference_generator
// Carrot waypoint follower with speed, acceleration and yaw-rate limits
// ----------------------------------------------------------------------------
// waypoint stored in the push state; empty path and ignored command handled in idle
// tick: longer when following than when braking, and longer for each waypoint
//   dropped; set by the shared 32-step square root and divider
// one item at a time; the next item is taken once the current one is done
// reset: synchronous active low, reference and plan bookkeeping cleared,
//   registers to defaults; plan memory is not cleared (no clearing pass)
module waypoint_reference_generator #(
    parameter int PLAN_DEPTH = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    wrg_cfg_if.sink    i_cfg,
    wrg_in_if.sink     i_in,
    wrg_out_if.source  o_out
);
    import wrg_pkg::*;

    localparam int AW = (PLAN_DEPTH > 1) ? $clog2(PLAN_DEPTH) : 1;
    localparam int CW = $clog2(PLAN_DEPTH + 1);
    localparam int SW = CW + 1;

    // ------------------------------------------------------------------
    // registers
    // ------------------------------------------------------------------
    t_state r_state, n_state;

    // configuration
    logic [16:0] r_cfg_dt,    n_cfg_dt;
    logic [30:0] r_cfg_tol,   n_cfg_tol;
    logic [30:0] r_cfg_look,  n_cfg_look;
    logic [30:0] r_cfg_vmax,  n_cfg_vmax;
    logic [30:0] r_cfg_amax,  n_cfg_amax;
    logic [30:0] r_cfg_yawr,  n_cfg_yawr;
    logic [15:0] r_cfg_stale, n_cfg_stale;

    // reference state, index 0 east (x), 1 north (y), 2 up (z)
    logic signed [31:0] r_pos [3];
    logic signed [31:0] n_pos [3];
    logic signed [31:0] r_vel [3];
    logic signed [31:0] n_vel [3];
    logic signed [31:0] r_yaw, n_yaw;

    // plan bookkeeping
    logic [AW-1:0] r_head,  n_head;
    logic [CW-1:0] r_count, n_count;
    logic          r_has_plan, n_has_plan;
    logic [15:0]   r_ticks, n_ticks;
    logic [3:0]    r_startup, n_startup;

    // work registers
    t_point             r_wp, n_wp;
    logic signed [31:0] r_d [3];
    logic signed [31:0] n_d [3];
    logic [1:0]         r_k, n_k;
    logic [63:0]        r_acc, n_acc;
    logic [63:0]        r_sq_n, n_sq_n;
    logic [63:0]        r_sq_r, n_sq_r;
    logic [63:0]        r_sq_bit, n_sq_bit;
    logic [31:0]        r_n, n_n;
    logic [63:0]        r_rem, n_rem;
    logic [63:0]        r_dsh, n_dsh;
    logic [31:0]        r_q, n_q;
    logic               r_qneg, n_qneg;
    logic [4:0]         r_cnt, n_cnt;
    logic signed [35:0] r_cx, n_cx;
    logic signed [35:0] r_cy, n_cy;
    logic signed [33:0] r_cz, n_cz;
    logic signed [33:0] r_ang, n_ang;
    logic [31:0]        r_dvmax, n_dvmax;
    logic [31:0]        r_speed, n_speed;
    logic [31:0]        r_s, n_s;
    t_state             r_ret, n_ret;
    t_state             r_dret, n_dret;
    t_state             r_wret, n_wret;
    logic               r_brake, n_brake;
    logic               r_engage, n_engage;
    logic signed [65:0] r_prod, n_prod;

    // result register
    logic               r_out_valid, n_out_valid;
    logic signed [31:0] r_north, n_north;
    logic signed [31:0] r_east, n_east;
    logic signed [31:0] r_down, n_down;
    logic signed [19:0] r_heading, n_heading;
    logic               r_engage_o, n_engage_o;
    logic               r_plan_o, n_plan_o;

    // plan memory, one entry per waypoint
    t_point        r_mem [PLAN_DEPTH];
    t_point        r_rd;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [AW-1:0] mem_raddr;
    t_point        mem_wdata;

    // ------------------------------------------------------------------
    // combinational helpers
    // ------------------------------------------------------------------
    logic [AW-1:0]      head_p1;
    logic [SW-1:0]      push_sum;
    logic [AW-1:0]      push_idx;
    logic signed [32:0] mul_a, mul_b;
    logic               div_start;
    logic signed [65:0] div_num;
    logic signed [65:0] div_mag;
    logic [31:0]        div_den;
    logic               div_ge;
    logic [63:0]        sq_trial;
    logic               sq_ge;
    logic signed [32:0] q_s;
    logic signed [35:0] cx_sh, cy_sh;
    logic signed [33:0] atan_v;
    logic [15:0]        tick_inc;
    logic signed [31:0] heading_sum;
    logic signed [33:0] mdy;
    logic signed [33:0] dyaw;
    logic               in_ready;

    assign head_p1   = (r_head == AW'(PLAN_DEPTH - 1)) ? '0 : r_head + AW'(1);
    assign push_sum  = SW'(r_head) + SW'(r_count);
    assign push_idx  = (push_sum >= SW'(PLAN_DEPTH)) ? AW'(push_sum - SW'(PLAN_DEPTH))
                                                    : AW'(push_sum);
    assign mem_raddr = head_p1;

    // one shared multiplier, result always registered
    assign n_prod = mul_a * mul_b;

    // restoring divider step on magnitudes
    assign div_mag = div_num[65] ? -div_num : div_num;
    assign div_ge  = (r_rem >= r_dsh);
    assign q_s     = r_qneg ? -$signed({1'b0, r_q}) : $signed({1'b0, r_q});

    // bit-pair square root step
    assign sq_trial = r_sq_r + r_sq_bit;
    assign sq_ge    = (r_sq_n >= sq_trial);

    // cordic step, shifts round toward minus infinity
    assign cx_sh  = r_cx >>> r_cnt;
    assign cy_sh  = r_cy >>> r_cnt;
    assign atan_v = $signed({17'b0, atan_entry(r_cnt)});

    assign tick_inc    = (r_ticks != TICKS_MAX) ? r_ticks + 16'd1 : r_ticks;
    assign heading_sum = r_yaw + Q_PI_2;
    assign mdy         = $signed({2'b0, r_prod[47:16]});
    assign dyaw        = (r_ang > mdy) ? mdy : ((r_ang < -mdy) ? -mdy : r_ang);

    assign in_ready    = (r_state == S_IDLE);
    assign i_in.ready  = in_ready;
    assign i_cfg.ready = 1'b1;

    assign o_out.valid       = r_out_valid;
    assign o_out.north       = r_north;
    assign o_out.east        = r_east;
    assign o_out.down        = r_down;
    assign o_out.heading_ned = r_heading;
    assign o_out.engage_now  = r_engage_o;
    assign o_out.plan_active = r_plan_o;

    // ------------------------------------------------------------------
    // sequencer: next state and datapath
    // ------------------------------------------------------------------
    always_comb begin
        n_state     = r_state;
        n_cfg_dt    = r_cfg_dt;
        n_cfg_tol   = r_cfg_tol;
        n_cfg_look  = r_cfg_look;
        n_cfg_vmax  = r_cfg_vmax;
        n_cfg_amax  = r_cfg_amax;
        n_cfg_yawr  = r_cfg_yawr;
        n_cfg_stale = r_cfg_stale;
        n_pos       = r_pos;
        n_vel       = r_vel;
        n_yaw       = r_yaw;
        n_head      = r_head;
        n_count     = r_count;
        n_has_plan  = r_has_plan;
        n_ticks     = r_ticks;
        n_startup   = r_startup;
        n_wp        = r_wp;
        n_d         = r_d;
        n_k         = r_k;
        n_acc       = r_acc;
        n_sq_n      = r_sq_n;
        n_sq_r      = r_sq_r;
        n_sq_bit    = r_sq_bit;
        n_n         = r_n;
        n_rem       = r_rem;
        n_dsh       = r_dsh;
        n_q         = r_q;
        n_qneg      = r_qneg;
        n_cnt       = r_cnt;
        n_cx        = r_cx;
        n_cy        = r_cy;
        n_cz        = r_cz;
        n_ang       = r_ang;
        n_dvmax     = r_dvmax;
        n_speed     = r_speed;
        n_s         = r_s;
        n_ret       = r_ret;
        n_dret      = r_dret;
        n_wret      = r_wret;
        n_brake     = r_brake;
        n_engage    = r_engage;
        n_out_valid = r_out_valid;
        n_north     = r_north;
        n_east      = r_east;
        n_down      = r_down;
        n_heading   = r_heading;
        n_engage_o  = r_engage_o;
        n_plan_o    = r_plan_o;

        mem_we    = 1'b0;
        mem_waddr = push_idx;
        mem_wdata = r_wp;
        mul_a     = '0;
        mul_b     = '0;
        div_start = 1'b0;
        div_num   = '0;
        div_den   = '0;

        if (r_out_valid && o_out.ready) begin
            n_out_valid = 1'b0;
        end

        // register writes, value truncated to the register width
        if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_TICK_PERIOD: n_cfg_dt    = i_cfg.data[16:0];
                CFG_ARRIVE_TOL:  n_cfg_tol   = i_cfg.data;
                CFG_LOOKAHEAD:   n_cfg_look  = i_cfg.data;
                CFG_SPEED_LIM:   n_cfg_vmax  = i_cfg.data;
                CFG_ACCEL_LIM:   n_cfg_amax  = i_cfg.data;
                CFG_YAW_RATE:    n_cfg_yawr  = i_cfg.data;
                CFG_STALE_TICKS: n_cfg_stale = i_cfg.data[15:0];
                default: ;
            endcase
        end

        case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    case (t_cmd'(i_in.command))
                        CMD_WAYPOINT: begin
                            n_ticks = '0;
                            n_wp.x  = i_in.waypoint_x;
                            n_wp.y  = i_in.waypoint_y;
                            n_wp.z  = i_in.waypoint_z;
                            // new path: restart the ring, seeded with the reference
                            if (i_in.first_of_path) begin
                                n_head      = '0;
                                n_count     = CW'(1);
                                mem_we      = 1'b1;
                                mem_waddr   = '0;
                                mem_wdata.x = r_pos[0];
                                mem_wdata.y = r_pos[1];
                                mem_wdata.z = r_pos[2];
                            end
                            n_state = S_PUSH;
                        end
                        CMD_EMPTY: begin
                            n_ticks    = '0;
                            n_head     = '0;
                            n_count    = '0;
                            n_has_plan = 1'b0;
                        end
                        CMD_TICK: begin
                            n_engage = (r_startup == STARTUP_END - 4'd1);
                            n_ticks  = tick_inc;
                            if (r_startup < STARTUP_END) begin
                                n_startup = r_startup + 4'd1;
                            end
                            if (!r_has_plan || (tick_inc > r_cfg_stale)) begin
                                // brake toward standstill
                                for (int i = 0; i < 3; i++) begin
                                    n_d[i] = sat32(-ext34(r_vel[i]));
                                end
                                n_brake = 1'b1;
                                n_state = S_LIM;
                            end else begin
                                n_brake = 1'b0;
                                n_state = S_DROP_CHK;
                            end
                        end
                        default: ;
                    endcase
                end
            end

            S_PUSH: begin
                // a full store drops the waypoint
                if (r_count < CW'(PLAN_DEPTH)) begin
                    mem_we     = 1'b1;
                    n_count    = r_count + CW'(1);
                    n_has_plan = (r_count >= CW'(1));
                end else begin
                    n_has_plan = (r_count >= CW'(2));
                end
                n_state = S_IDLE;
            end

            // --- drop reached waypoints ---
            S_DROP_CHK: begin
                if (r_count < CW'(2)) begin
                    // plan exhausted, reference held this tick
                    n_has_plan = 1'b0;
                    n_state    = S_EMIT;
                end else begin
                    n_state = S_DROP_RD;
                end
            end

            S_DROP_RD: begin
                n_d[0]  = sat32(ext34(r_rd.x) - ext34(r_pos[0]));
                n_d[1]  = sat32(ext34(r_rd.y) - ext34(r_pos[1]));
                n_d[2]  = sat32(ext34(r_rd.z) - ext34(r_pos[2]));
                n_ret   = S_DROP_CMP;
                n_k     = '0;
                n_acc   = '0;
                n_state = S_SQ_MUL;
            end

            S_DROP_CMP: begin
                if (r_n < {1'b0, r_cfg_tol}) begin
                    n_head  = head_p1;
                    n_count = r_count - CW'(1);
                    n_state = S_DROP_CHK;
                end else begin
                    n_state = S_CAR;
                end
            end

            // --- carrot velocity ---
            S_CAR: begin
                if (r_n == '0) begin
                    for (int i = 0; i < 3; i++) begin
                        n_d[i] = sat32(-ext34(r_vel[i]));
                    end
                    n_state = S_LIM;
                end else begin
                    n_s = ({1'b0, r_cfg_look} < r_n) ? {1'b0, r_cfg_look} : r_n;
                    if (r_cfg_dt == '0) begin
                        n_speed = {1'b0, r_cfg_vmax};
                        n_k     = '0;
                        n_state = S_VD_MUL;
                    end else begin
                        n_state = S_CAR_MUL;
                    end
                end
            end

            S_CAR_MUL: begin
                mul_a   = $signed({2'b0, r_cfg_vmax});
                mul_b   = $signed({16'b0, r_cfg_dt});
                n_state = S_CAR_CMP;
            end

            S_CAR_CMP: begin
                // s/dt < speed limit is s*2^16 < limit*dt
                if ($signed({18'b0, r_s, 16'b0}) < r_prod) begin
                    div_start = 1'b1;
                    div_num   = $signed({18'b0, r_s, 16'b0});
                    div_den   = {15'b0, r_cfg_dt};
                    n_dret    = S_SPD_SET;
                    n_state   = S_DIV;
                end else begin
                    n_speed = {1'b0, r_cfg_vmax};
                    n_k     = '0;
                    n_state = S_VD_MUL;
                end
            end

            S_SPD_SET: begin
                n_speed = r_q;
                n_k     = '0;
                n_state = S_VD_MUL;
            end

            S_VD_MUL: begin
                mul_a   = $signed({r_d[r_k][31], r_d[r_k]});
                mul_b   = $signed({1'b0, r_speed});
                n_state = S_VD_DIV;
            end

            S_VD_DIV: begin
                div_start = 1'b1;
                div_num   = r_prod;
                div_den   = r_n;
                n_dret    = S_VD_SET;
                n_state   = S_DIV;
            end

            S_VD_SET: begin
                // velocity change wanted toward the carrot
                n_d[r_k] = sat32({q_s[32], q_s} - ext34(r_vel[r_k]));
                if (r_k == 2'd2) begin
                    n_state = S_LIM;
                end else begin
                    n_k     = r_k + 2'd1;
                    n_state = S_VD_MUL;
                end
            end

            // --- acceleration limit and integration ---
            S_LIM: begin
                mul_a   = $signed({2'b0, r_cfg_amax});
                mul_b   = $signed({16'b0, r_cfg_dt});
                n_state = S_LIM_DV;
            end

            S_LIM_DV: begin
                n_dvmax = r_prod[47:16];
                n_ret   = S_LIM_CMP;
                n_k     = '0;
                n_acc   = '0;
                n_state = S_SQ_MUL;
            end

            S_LIM_CMP: begin
                n_k     = '0;
                n_state = (r_n > r_dvmax) ? S_SC_MUL : S_VEL;
            end

            S_SC_MUL: begin
                mul_a   = $signed({r_d[r_k][31], r_d[r_k]});
                mul_b   = $signed({1'b0, r_dvmax});
                n_state = S_SC_DIV;
            end

            S_SC_DIV: begin
                div_start = 1'b1;
                div_num   = r_prod;
                div_den   = r_n;
                n_dret    = S_SC_SET;
                n_state   = S_DIV;
            end

            S_SC_SET: begin
                n_d[r_k] = q_s[31:0];
                if (r_k == 2'd2) begin
                    n_state = S_VEL;
                end else begin
                    n_k     = r_k + 2'd1;
                    n_state = S_SC_MUL;
                end
            end

            S_VEL: begin
                for (int i = 0; i < 3; i++) begin
                    n_vel[i] = sat32(ext34(r_vel[i]) + ext34(r_d[i]));
                end
                n_k     = '0;
                n_state = S_POS_MUL;
            end

            S_POS_MUL: begin
                mul_a   = $signed({r_vel[r_k][31], r_vel[r_k]});
                mul_b   = $signed({16'b0, r_cfg_dt});
                n_state = S_POS_ADD;
            end

            S_POS_ADD: begin
                n_pos[r_k] = sat32(ext34(r_pos[r_k]) + tz16(r_prod));
                if (r_k == 2'd2) begin
                    n_state = r_brake ? S_EMIT : S_YAW;
                end else begin
                    n_k     = r_k + 2'd1;
                    n_state = S_POS_MUL;
                end
            end

            // --- yaw toward horizontal velocity ---
            S_YAW: begin
                n_d[0]  = r_vel[0];
                n_d[1]  = r_vel[1];
                n_d[2]  = '0;
                n_ret   = S_YAW_CMP;
                n_k     = '0;
                n_acc   = '0;
                n_state = S_SQ_MUL;
            end

            S_YAW_CMP: begin
                if (r_n > YAW_SPEED_MIN) begin
                    // quadrant pre-rotation for the left half plane
                    n_cnt = '0;
                    if (r_vel[0] < 0) begin
                        n_cz = (r_vel[1] >= 0) ? Q_PI : -Q_PI;
                        n_cx = -$signed({{4{r_vel[0][31]}}, r_vel[0]});
                        n_cy = -$signed({{4{r_vel[1][31]}}, r_vel[1]});
                    end else begin
                        n_cz = '0;
                        n_cx = $signed({{4{r_vel[0][31]}}, r_vel[0]});
                        n_cy = $signed({{4{r_vel[1][31]}}, r_vel[1]});
                    end
                    n_state = S_CORDIC;
                end else begin
                    // target is the present yaw
                    n_ang   = '0;
                    n_state = S_MDY_MUL;
                end
            end

            S_CORDIC: begin
                if (r_cy > 0) begin
                    n_cx = r_cx + cy_sh;
                    n_cy = r_cy - cx_sh;
                    n_cz = r_cz + atan_v;
                end else begin
                    n_cx = r_cx - cy_sh;
                    n_cy = r_cy + cx_sh;
                    n_cz = r_cz - atan_v;
                end
                n_cnt = r_cnt + 5'd1;
                if (r_cnt == CORDIC_LAST) begin
                    n_ang   = n_cz - ext34(r_yaw);
                    n_wret  = S_MDY_MUL;
                    n_state = S_WRAP;
                end
            end

            S_WRAP: begin
                if (r_ang > Q_PI) begin
                    n_ang = r_ang - Q_TWO_PI;
                end else if (r_ang < -Q_PI) begin
                    n_ang = r_ang + Q_TWO_PI;
                end else begin
                    n_state = r_wret;
                end
            end

            S_MDY_MUL: begin
                mul_a   = $signed({2'b0, r_cfg_yawr});
                mul_b   = $signed({16'b0, r_cfg_dt});
                n_state = S_CLAMP;
            end

            S_CLAMP: begin
                n_ang   = ext34(r_yaw) + dyaw;
                n_wret  = S_YAW_SET;
                n_state = S_WRAP;
            end

            S_YAW_SET: begin
                n_yaw   = r_ang[31:0];
                n_state = S_EMIT;
            end

            S_EMIT: begin
                if (!r_out_valid || o_out.ready) begin
                    n_out_valid = 1'b1;
                    n_north     = r_pos[1];
                    n_east      = r_pos[0];
                    n_down      = sat32(-ext34(r_pos[2]));
                    n_heading   = heading_sum[19:0];
                    n_engage_o  = r_engage;
                    n_plan_o    = r_has_plan;
                    n_state     = S_IDLE;
                end
            end

            // --- norm: sum of squares, then square root ---
            S_SQ_MUL: begin
                mul_a   = $signed({r_d[r_k][31], r_d[r_k]});
                mul_b   = $signed({r_d[r_k][31], r_d[r_k]});
                n_state = S_SQ_ACC;
            end

            S_SQ_ACC: begin
                n_acc = r_acc + r_prod[63:0];
                if (r_k == 2'd2) begin
                    n_sq_n   = r_acc + r_prod[63:0];
                    n_sq_r   = '0;
                    n_sq_bit = SQRT_BIT_TOP;
                    n_cnt    = '0;
                    n_state  = S_SQRT;
                end else begin
                    n_k     = r_k + 2'd1;
                    n_state = S_SQ_MUL;
                end
            end

            S_SQRT: begin
                if (sq_ge) begin
                    n_sq_n = r_sq_n - sq_trial;
                    n_sq_r = (r_sq_r >> 1) + r_sq_bit;
                end else begin
                    n_sq_r = r_sq_r >> 1;
                end
                n_sq_bit = r_sq_bit >> 2;
                n_cnt    = r_cnt + 5'd1;
                if (r_cnt == STEP_LAST) begin
                    n_n     = n_sq_r[31:0];
                    n_state = r_ret;
                end
            end

            // --- divide, one quotient bit per cycle ---
            S_DIV: begin
                if (div_ge) begin
                    n_rem = r_rem - r_dsh;
                    n_q   = {r_q[30:0], 1'b1};
                end else begin
                    n_q   = {r_q[30:0], 1'b0};
                end
                n_dsh = r_dsh >> 1;
                n_cnt = r_cnt + 5'd1;
                if (r_cnt == STEP_LAST) begin
                    n_state = r_dret;
                end
            end

            default: n_state = S_IDLE;
        endcase

        // divider load, quotient truncates toward zero
        if (div_start) begin
            n_rem  = div_mag[63:0];
            n_dsh  = {1'b0, div_den, 31'b0};
            n_q    = '0;
            n_qneg = div_num[65];
            n_cnt  = '0;
        end
    end

    // ------------------------------------------------------------------
    // control and reference state
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cfg_dt    <= RST_TICK_PERIOD;
            r_cfg_tol   <= RST_ARRIVE_TOL;
            r_cfg_look  <= RST_LOOKAHEAD;
            r_cfg_vmax  <= RST_SPEED_LIM;
            r_cfg_amax  <= RST_ACCEL_LIM;
            r_cfg_yawr  <= RST_YAW_RATE;
            r_cfg_stale <= RST_STALE_TICKS;
            for (int i = 0; i < 3; i++) begin
                r_pos[i] <= '0;
                r_vel[i] <= '0;
            end
            r_yaw       <= '0;
            r_head      <= '0;
            r_count     <= '0;
            r_has_plan  <= 1'b0;
            r_ticks     <= '0;
            r_startup   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cfg_dt    <= n_cfg_dt;
            r_cfg_tol   <= n_cfg_tol;
            r_cfg_look  <= n_cfg_look;
            r_cfg_vmax  <= n_cfg_vmax;
            r_cfg_amax  <= n_cfg_amax;
            r_cfg_yawr  <= n_cfg_yawr;
            r_cfg_stale <= n_cfg_stale;
            r_pos       <= n_pos;
            r_vel       <= n_vel;
            r_yaw       <= n_yaw;
            r_head      <= n_head;
            r_count     <= n_count;
            r_has_plan  <= n_has_plan;
            r_ticks     <= n_ticks;
            r_startup   <= n_startup;
            r_out_valid <= n_out_valid;
        end
    end

    // ------------------------------------------------------------------
    // work and result payload
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        r_wp       <= n_wp;
        r_d        <= n_d;
        r_k        <= n_k;
        r_acc      <= n_acc;
        r_sq_n     <= n_sq_n;
        r_sq_r     <= n_sq_r;
        r_sq_bit   <= n_sq_bit;
        r_n        <= n_n;
        r_rem      <= n_rem;
        r_dsh      <= n_dsh;
        r_q        <= n_q;
        r_qneg     <= n_qneg;
        r_cnt      <= n_cnt;
        r_cx       <= n_cx;
        r_cy       <= n_cy;
        r_cz       <= n_cz;
        r_ang      <= n_ang;
        r_dvmax    <= n_dvmax;
        r_speed    <= n_speed;
        r_s        <= n_s;
        r_ret      <= n_ret;
        r_dret     <= n_dret;
        r_wret     <= n_wret;
        r_brake    <= n_brake;
        r_engage   <= n_engage;
        r_prod     <= n_prod;
        r_north    <= n_north;
        r_east     <= n_east;
        r_down     <= n_down;
        r_heading  <= n_heading;
        r_engage_o <= n_engage_o;
        r_plan_o   <= n_plan_o;
    end

    // ------------------------------------------------------------------
    // plan memory: one write port, registered read
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rd <= r_mem[mem_raddr];
    end

endmodule
